// ===== rtl/core/txgm_pkg.sv =====
// ----------------------------------------------------------------------------
// txgm_pkg
// Types and constants shared by the transcript-to-genome interval mapper.
// ----------------------------------------------------------------------------
package txgm_pkg;

    localparam int DATA_W          = 32;
    localparam int MAX_EXONS_DEF   = 64;
    localparam int PIECE_LIMIT     = 64;
    localparam int PIECE_CNT_W     = $clog2(PIECE_LIMIT + 1);
    localparam int PIECE_IDX_W     = 6;

    typedef enum logic [1:0] {
        MODE_BEGIN  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_MAP    = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_MISS = 2'd1,
        STATUS_CLIP = 2'd2
    } status_t;

    typedef struct packed {
        mode_t              mode;
        logic [DATA_W-1:0]  value_a;
        logic [DATA_W-1:0]  value_b;
        logic               minus_flag;
    } in_item_t;

    typedef struct packed {
        status_t                 status;
        logic [DATA_W-1:0]       genome_start;
        logic [DATA_W-1:0]       genome_end;
        logic [DATA_W-1:0]       piece_offset;
        logic [DATA_W-1:0]       piece_length;
        logic [PIECE_IDX_W-1:0]  piece_index;
        logic                    last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_EMIT_START,
        ST_EMIT,
        ST_MISS
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic begin_tx;
        logic append;
        logic walk_start;
        logic walk_step;
        logic emit_start;
        logic emit_step;
        logic load_miss;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic count_zero;
        logic walk_active;
        logic walk_stop;
        logic last_exon;
        logic slot_free;
        logic emit_last;
    } dp_stat_t;

endpackage

// ===== rtl/core/transcript_to_genome_interval_map_core.sv =====
// ----------------------------------------------------------------------------
// transcript_to_genome_interval_map_core
// Holds one transcript's exon table and maps transcript intervals to genomic
// pieces. Begin and append requests are handled in the idle state itself. A
// map request is accepted, walks the exons from the first one up to the exon
// that holds the interval end, the last exon or the piece limit (at most the
// exon count), passes a setup state, then emits its pieces while the result
// side is ready; a start outside all exons, or an empty table, gives a single
// miss result. The single read port of the exon table is read one entry per
// cycle while the walk or the emission advances. The block takes a new request
// only when idle; a last result may still wait to be taken while the next
// request is accepted.
module transcript_to_genome_interval_map_core
    import txgm_pkg::*;
#(
    parameter int MAX_EXONS = MAX_EXONS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_item
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    txgm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (in_item.mode),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    txgm_dpath #(
        .MAX_EXONS (MAX_EXONS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

// ===== rtl/core/txgm_ctrl.sv =====
// ----------------------------------------------------------------------------
// txgm_ctrl
// Sequencer for table updates, the exon walk and result emission.
// ----------------------------------------------------------------------------
module txgm_ctrl
    import txgm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  mode_t     mode,
    output logic      in_ready,
    output dp_cmd_t   cmd,
    input  dp_stat_t  stat
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (mode)
                        MODE_BEGIN:  cmd.begin_tx = 1'b1;
                        MODE_APPEND: cmd.append   = 1'b1;
                        MODE_MAP:
                        begin
                            cmd.walk_start = 1'b1;
                            state_next     = stat.count_zero ? ST_MISS : ST_WALK;
                        end
                        default: ;  // drop unused mode
                    endcase
                end
            end
            ST_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (stat.walk_active && (stat.walk_stop || stat.last_exon))
                begin
                    state_next = ST_EMIT_START;
                end
                else if (!stat.walk_active && stat.last_exon)
                begin
                    state_next = ST_MISS;
                end
            end
            ST_EMIT_START:
            begin
                cmd.emit_start = 1'b1;
                state_next     = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.slot_free)
                begin
                    cmd.emit_step = 1'b1;
                    if (stat.emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_MISS:
            begin
                if (stat.slot_free)
                begin
                    cmd.load_miss = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/txgm_dpath.sv =====
// ----------------------------------------------------------------------------
// txgm_dpath
// Exon table memory, walk arithmetic and the result register.
// ----------------------------------------------------------------------------
module txgm_dpath
    import txgm_pkg::*;
#(
    parameter int MAX_EXONS = MAX_EXONS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  in_item_t   in_item,
    input  dp_cmd_t    cmd,
    output dp_stat_t   stat,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_item
);

    localparam int AW    = (MAX_EXONS > 1) ? $clog2(MAX_EXONS) : 1;
    localparam int CW    = $clog2(MAX_EXONS + 1);
    localparam int LEN_W = DATA_W + $clog2(MAX_EXONS);
    localparam int SW    = LEN_W + 1;

    // Exon table: offset in the upper half, size in the lower half
    logic [2*DATA_W-1:0] exon_mem [MAX_EXONS];
    logic [2*DATA_W-1:0] rd_data_reg;

    // Transcript state
    logic [CW-1:0]      count_reg;
    logic [LEN_W-1:0]   txlen_reg;
    logic [DATA_W-1:0]  tx_start_reg;
    logic               minus_reg;

    // Walk state
    logic signed [SW-1:0]   ts_reg;
    logic signed [SW-1:0]   te_reg;
    logic                   clipped_reg;
    logic [LEN_W-1:0]       base_reg;
    logic [LEN_W-1:0]       base_s_reg;
    logic [CW-1:0]          idx_reg;
    logic [CW-1:0]          s_reg;
    logic                   found_reg;
    logic                   done_reg;
    logic [PIECE_CNT_W-1:0] n_reg;
    logic [PIECE_CNT_W-1:0] emit_n_reg;
    logic [DATA_W:0]        start_rel_reg;
    logic [DATA_W:0]        end_rel_reg;
    logic [DATA_W-1:0]      gstart_reg;
    logic [DATA_W-1:0]      gend_reg;
    status_t                status_reg;

    logic                   out_valid_reg;
    out_item_t              out_item_reg;
    out_item_t              piece_item;
    out_item_t              miss_item;

    logic                   table_full;
    logic                   rd_en;
    logic [CW-1:0]          idx_next;

    logic [DATA_W-1:0]      off;
    logic [DATA_W-1:0]      size;
    logic signed [SW-1:0]   base_s;
    logic signed [SW-1:0]   size_s;
    logic [LEN_W-1:0]       blk_end;
    logic signed [SW-1:0]   blk_end_s;
    logic                   hit;
    logic                   active;
    logic signed [SW-1:0]   te_minus_base;
    logic signed [SW-1:0]   ts_minus_base;
    logic [DATA_W-1:0]      span;
    logic [DATA_W:0]        end_rel_next;
    logic [DATA_W:0]        start_rel_next;
    logic [PIECE_CNT_W-1:0] n_next;

    logic signed [SW-1:0]   txlen_s;
    logic signed [SW-1:0]   a_s;
    logic signed [SW-1:0]   b_s;
    logic signed [SW-1:0]   ts0;
    logic signed [SW-1:0]   te0;
    logic signed [SW-1:0]   te1;
    logic                   clip0;

    logic                   first;
    logic signed [SW-1:0]   lo;
    logic signed [SW-1:0]   hi;
    logic signed [SW-1:0]   len_full;
    logic [DATA_W-1:0]      piece_off;

    logic [DATA_W+1:0]      gstart_sum;
    logic [DATA_W+1:0]      gend_sum;
    logic                   slot_free;

    assign table_full = (count_reg == CW'(MAX_EXONS));
    assign slot_free  = !out_valid_reg || out_ready;

    // Query setup: flip on minus strand, raise an inverted end, clip to length
    assign txlen_s = $signed({1'b0, txlen_reg});
    assign a_s     = $signed({{(SW-DATA_W){1'b0}}, in_item.value_a});
    assign b_s     = $signed({{(SW-DATA_W){1'b0}}, in_item.value_b});
    assign ts0     = minus_reg ? (txlen_s - b_s) : a_s;
    assign te0     = minus_reg ? (txlen_s - a_s) : b_s;
    assign te1     = (te0 < ts0) ? ts0 : te0;
    assign clip0   = (te1 > txlen_s);

    // Walk step on the exon held in the read register
    assign off            = rd_data_reg[2*DATA_W-1:DATA_W];
    assign size           = rd_data_reg[DATA_W-1:0];
    assign base_s         = $signed({1'b0, base_reg});
    assign size_s         = $signed({{(SW-DATA_W){1'b0}}, size});
    assign blk_end        = base_reg + LEN_W'(size);
    assign blk_end_s      = $signed({1'b0, blk_end});
    assign hit            = !found_reg && (base_s <= ts_reg) && (ts_reg < blk_end_s);
    assign active         = found_reg || hit;
    assign te_minus_base  = te_reg - base_s;
    assign ts_minus_base  = ts_reg - base_s;
    assign span           = (te_minus_base < size_s) ? te_minus_base[DATA_W-1:0] : size;
    assign end_rel_next   = {1'b0, off} + {1'b0, span};
    assign start_rel_next = {1'b0, off} + {1'b0, ts_minus_base[DATA_W-1:0]};
    assign n_next         = n_reg + PIECE_CNT_W'(1);

    // Emission of one piece
    assign first     = (emit_n_reg == '0);
    assign lo        = first ? ts_reg : base_s;
    assign hi        = (te_reg < blk_end_s) ? te_reg : blk_end_s;
    assign len_full  = hi - lo;
    assign piece_off = first ? '0 : (off - start_rel_reg[DATA_W-1:0]);

    assign gstart_sum = {2'b00, tx_start_reg} + {1'b0, start_rel_reg};
    assign gend_sum   = {2'b00, tx_start_reg} + {1'b0, end_rel_reg};

    assign stat.count_zero  = (count_reg == '0);
    assign stat.walk_active = active;
    assign stat.walk_stop   = (te_reg <= blk_end_s) || (n_next == PIECE_CNT_W'(PIECE_LIMIT));
    assign stat.last_exon   = ((idx_reg + CW'(1)) == count_reg);
    assign stat.slot_free   = slot_free;
    assign stat.emit_last   = ((emit_n_reg + PIECE_CNT_W'(1)) == n_reg);

    assign rd_en = cmd.walk_start || cmd.walk_step || cmd.emit_start || cmd.emit_step;

    always_comb
    begin
        if (cmd.walk_start)
        begin
            idx_next = '0;
        end
        else if (cmd.emit_start)
        begin
            idx_next = s_reg;
        end
        else
        begin
            idx_next = idx_reg + CW'(1);
        end
    end

    // Result words for one piece and for a start outside all exons
    always_comb
    begin
        piece_item.status       = status_reg;
        piece_item.genome_start = gstart_reg;
        piece_item.genome_end   = gend_reg;
        piece_item.piece_offset = piece_off;
        piece_item.piece_length = len_full[DATA_W-1:0];
        piece_item.piece_index  = emit_n_reg[PIECE_IDX_W-1:0];
        piece_item.last         = ((emit_n_reg + PIECE_CNT_W'(1)) == n_reg);

        miss_item        = '0;
        miss_item.status = STATUS_MISS;
        miss_item.last   = 1'b1;
    end

    // Exon table memory
    always_ff @(posedge clk)
    begin
        if (cmd.append && !table_full)
        begin
            exon_mem[count_reg[AW-1:0]] <= {in_item.value_a, in_item.value_b};
        end
        if (rd_en)
        begin
            rd_data_reg <= exon_mem[idx_next[AW-1:0]];
        end
    end

    // Control and transcript state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            txlen_reg     <= '0;
            tx_start_reg  <= '0;
            minus_reg     <= 1'b0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            done_reg      <= 1'b0;
            n_reg         <= '0;
            emit_n_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.begin_tx)
            begin
                count_reg    <= '0;
                txlen_reg    <= '0;
                tx_start_reg <= in_item.value_a;
                minus_reg    <= in_item.minus_flag;
            end
            if (cmd.append && !table_full)
            begin
                count_reg <= count_reg + CW'(1);
                txlen_reg <= txlen_reg + LEN_W'(in_item.value_b);
            end
            if (rd_en)
            begin
                idx_reg <= idx_next;
            end
            if (cmd.walk_start)
            begin
                found_reg <= 1'b0;
                done_reg  <= 1'b0;
                n_reg     <= '0;
            end
            if (cmd.walk_step && active)
            begin
                found_reg <= 1'b1;
                done_reg  <= (te_reg <= blk_end_s);
                n_reg     <= n_next;
            end
            if (cmd.emit_start)
            begin
                emit_n_reg <= '0;
            end
            if (cmd.emit_step)
            begin
                emit_n_reg <= emit_n_reg + PIECE_CNT_W'(1);
            end
            if (cmd.emit_step || cmd.load_miss)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Walk and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.walk_start)
        begin
            ts_reg      <= ts0;
            te_reg      <= clip0 ? txlen_s : te1;
            clipped_reg <= clip0;
            base_reg    <= '0;
        end
        if (cmd.walk_step)
        begin
            base_reg <= blk_end;
            if (active)
            begin
                end_rel_reg <= end_rel_next;
            end
            if (hit)
            begin
                s_reg         <= idx_reg;
                base_s_reg    <= base_reg;
                start_rel_reg <= start_rel_next;
            end
        end
        if (cmd.emit_start)
        begin
            base_reg   <= base_s_reg;
            gstart_reg <= (|gstart_sum[DATA_W+1:DATA_W]) ? '1 : gstart_sum[DATA_W-1:0];
            gend_reg   <= (|gend_sum[DATA_W+1:DATA_W]) ? '1 : gend_sum[DATA_W-1:0];
            status_reg <= (clipped_reg || !done_reg) ? STATUS_CLIP : STATUS_OK;
        end
        if (cmd.emit_step)
        begin
            base_reg     <= blk_end;
            out_item_reg <= piece_item;
        end
        else if (cmd.load_miss)
        begin
            out_item_reg <= miss_item;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_step || cmd.load_miss) |-> slot_free)
        else $error("result loaded over a waiting result");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_EXONS))
        else $error("exon count beyond table depth");

    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_step |-> (idx_reg < count_reg))
        else $error("walk past the last exon");

    a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_step |-> (emit_n_reg < n_reg))
        else $error("more pieces emitted than walked");

endmodule
